>>> design/lkv_pkg.sv
// Package for the LRU key-value cache: port widths, register reset value,
// operation codes and the controller state type. No dependencies.
package lkv_pkg;

    localparam int KEY_PORT_W   = 32;
    localparam int VALUE_PORT_W = 32;
    localparam int CAP_W        = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_RESP = 3'b100
    } t_state;

endpackage

>>> design/lkv_if.sv
// Request and response channel interfaces of the LRU key-value cache.
// Depends on lkv_pkg for the payload widths.
interface lkv_req_if import lkv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [KEY_PORT_W-1:0]   key;
    logic [VALUE_PORT_W-1:0] value;

    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [VALUE_PORT_W-1:0] read_value;
    logic                    evicted;

    modport source (output valid, hit, read_value, evicted, input ready);
    modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

>>> design/lkv_dir.sv
// Key directory of the LRU key-value cache: stored keys, recency ranks and
// entry count, with parallel match, victim choice and rank update.
// Depends on lkv_pkg.
module lkv_dir import lkv_pkg::*; #(
    parameter int ENTRIES = 8,
    parameter int KEY_W   = 32,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_lookup,
    input  logic             i_kind,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CNT_W-1:0] i_cap,
    output logic             o_hit,
    output logic             o_evict,
    output logic [IDX_W-1:0] o_slot
);

    logic [KEY_W-1:0] r_keys [ENTRIES];
    logic [IDX_W-1:0] r_rank [ENTRIES];
    logic [IDX_W-1:0] n_rank [ENTRIES];
    logic [CNT_W-1:0] r_count;

    logic             hit;
    logic             victim_found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] victim_idx;
    logic [IDX_W-1:0] last_rank;
    logic [IDX_W-1:0] old_rank;
    logic             fill;
    logic             evict;
    logic             touch;
    logic [IDX_W-1:0] slot;
    logic             valid_j;

    assign last_rank = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        hit          = 1'b0;
        hit_idx      = '0;
        victim_found = 1'b0;
        victim_idx   = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            if (CNT_W'(j) < r_count) begin
                if (!hit && r_keys[j] == i_key) begin
                    hit     = 1'b1;
                    hit_idx = IDX_W'(j);
                end
                if (!victim_found && r_rank[j] == last_rank) begin
                    victim_found = 1'b1;
                    victim_idx   = IDX_W'(j);
                end
            end
        end
    end

    assign fill  = !hit && (i_kind == KIND_PUT) && (r_count < i_cap);
    assign evict = !hit && (i_kind == KIND_PUT) && !fill;
    assign touch = hit || evict;
    assign slot  = hit ? hit_idx : (fill ? IDX_W'(r_count) : victim_idx);
    assign old_rank = r_rank[slot];

    always_comb begin
        valid_j = 1'b0;
        for (int j = 0; j < ENTRIES; j++) begin
            valid_j   = CNT_W'(j) < r_count;
            n_rank[j] = r_rank[j];
            if (IDX_W'(j) == slot && (touch || fill)) begin
                n_rank[j] = '0;
            end else if (valid_j && (fill || (touch && r_rank[j] < old_rank))) begin
                n_rank[j] = r_rank[j] + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int j = 0; j < ENTRIES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_lookup) begin
            for (int j = 0; j < ENTRIES; j++) begin
                r_rank[j] <= n_rank[j];
            end
            if (fill) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lookup && (fill || evict)) begin
            r_keys[slot] <= i_key;
        end
    end

    assign o_hit   = hit;
    assign o_evict = evict;
    assign o_slot  = slot;

endmodule

>>> design/lru_key_value_cache.sv
// LRU key-value cache, top level. A request is captured; in the lookup
// state the directory lookup and the value memory access happen together;
// the response state registers the result to the output and can take a new
// request unless the output is stalled. Reset clears the entry count, recency
// ranks and controller; capacity returns to 8. Key and value storage is not
// cleared; no clearing pass. Depends on lkv_pkg, lkv_if and lkv_dir.
module lru_key_value_cache import lkv_pkg::*; #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lkv_req_if.sink          i_req,
    lkv_rsp_if.source        o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int VAL_W = (VALUE_BITS < VALUE_PORT_W) ? VALUE_BITS : VALUE_PORT_W;

    t_state             r_state;
    logic [CAP_W-1:0]   r_cap;
    logic               r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic               r_hit;
    logic               r_evict;
    logic [VAL_W-1:0]   r_rdata;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [VAL_W-1:0]   r_out_value;
    logic               r_out_evict;
    logic [VAL_W-1:0]   r_mem [ENTRIES];

    logic               out_free;
    logic               ready;
    logic               accept;
    logic               lookup;
    logic [CMP_W-1:0]   cap_wide;
    logic [CNT_W-1:0]   eff_cap;
    logic               dir_hit;
    logic               dir_evict;
    logic [IDX_W-1:0]   dir_slot;

    assign cap_wide = CMP_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_wide > CMP_W'(ENTRIES)) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(cap_wide);
        end
    end

    assign out_free = !r_out_valid || o_rsp.ready;
    assign ready    = (r_state == ST_IDLE) || (r_state == ST_RESP && out_free);
    assign accept   = i_req.valid && ready;
    assign lookup   = (r_state == ST_LOOK);

    lkv_dir #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_dir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (lookup),
        .i_kind   (r_kind),
        .i_key    (r_key),
        .i_cap    (eff_cap),
        .o_hit    (dir_hit),
        .o_evict  (dir_evict),
        .o_slot   (dir_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_state == ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_state <= accept ? ST_LOOK : ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // capture request, lookup results and response outputs
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_req.kind;
            r_key   <= i_req.key[KEY_W-1:0];
            r_value <= i_req.value[VAL_W-1:0];
        end
        if (lookup) begin
            r_hit   <= dir_hit;
            r_evict <= dir_evict;
        end
        if (r_state == ST_RESP && out_free) begin
            r_out_hit   <= r_hit;
            r_out_value <= (r_kind == KIND_GET && r_hit) ? r_rdata : '0;
            r_out_evict <= r_evict;
        end
    end

    // value memory: write on put, registered read on get
    always_ff @(posedge i_clk) begin
        if (lookup) begin
            if (r_kind == KIND_PUT) begin
                r_mem[dir_slot] <= r_value;
            end else begin
                r_rdata <= r_mem[dir_slot];
            end
        end
    end

    assign i_req.ready      = ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = VALUE_PORT_W'(r_out_value);
    assign o_rsp.evicted    = r_out_evict;

endmodule
